>>> design/acs_pkg.sv
// Shared types, constants and functions for the Arabic contextual shaper.
// Holds the queued job format, UTF-8 byte constants and the presentation-form tables.
// No dependencies.
`default_nettype none

package acs_pkg;

    // Code point width and UTF-8 framing constants
    localparam int unsigned C_CP_W        = 21;
    localparam int unsigned C_QUEUE_DEPTH = 2;

    localparam logic [7:0] C_ASCII_TOP = 8'h80;
    localparam logic [7:0] C_LEAD2     = 8'hC0;
    localparam logic [7:0] C_LEAD3     = 8'hE0;
    localparam logic [7:0] C_LEAD4     = 8'hF0;
    localparam logic [7:0] C_CONT      = 8'h80;

    // Joining letter ranges
    localparam logic [20:0] C_FIRST_LETTER = 21'h000622;
    localparam logic [20:0] C_GAP_LOW      = 21'h00063A;
    localparam logic [20:0] C_GAP_HIGH     = 21'h000641;
    localparam logic [20:0] C_LAST_LETTER  = 21'h00064A;

    // Encoded length of a code point: number of bytes minus one
    typedef enum logic [1:0] {
        LEN_1 = 2'd0,
        LEN_2 = 2'd1,
        LEN_3 = 2'd2,
        LEN_4 = 2'd3
    } t_len;

    // One queued job: one or two code points caused by a single input byte
    typedef struct packed {
        logic [C_CP_W-1:0] cp_a;
        logic [C_CP_W-1:0] cp_b;
        logic              has_b;
        logic              flush;
    } t_job;

    // True for a letter that joins
    function automatic logic letter_joins(input logic [C_CP_W-1:0] cp);
        return ((cp >= C_FIRST_LETTER) && (cp <= C_GAP_LOW)) ||
               ((cp >= C_GAP_HIGH) && (cp <= C_LAST_LETTER));
    endfunction

    // Isolated presentation form per letter, indexed from U+0622
    function automatic logic [15:0] form_base(input logic [5:0] idx);
        logic [15:0] base;
        case (idx)
            6'd0:    base = 16'hFE81;
            6'd1:    base = 16'hFE83;
            6'd2:    base = 16'hFE85;
            6'd3:    base = 16'hFE87;
            6'd4:    base = 16'hFE89;
            6'd5:    base = 16'hFE8D;
            6'd6:    base = 16'hFE8F;
            6'd7:    base = 16'hFE93;
            6'd8:    base = 16'hFE95;
            6'd9:    base = 16'hFE99;
            6'd10:   base = 16'hFE9D;
            6'd11:   base = 16'hFEA1;
            6'd12:   base = 16'hFEA5;
            6'd13:   base = 16'hFEA9;
            6'd14:   base = 16'hFEAB;
            6'd15:   base = 16'hFEAD;
            6'd16:   base = 16'hFEAF;
            6'd17:   base = 16'hFEB1;
            6'd18:   base = 16'hFEB5;
            6'd19:   base = 16'hFEB9;
            6'd20:   base = 16'hFEBD;
            6'd21:   base = 16'hFEC1;
            6'd22:   base = 16'hFEC5;
            6'd23:   base = 16'hFEC9;
            6'd24:   base = 16'hFECD;
            6'd31:   base = 16'hFED1;
            6'd32:   base = 16'hFED5;
            6'd33:   base = 16'hFED9;
            6'd34:   base = 16'hFEDD;
            6'd35:   base = 16'hFEE1;
            6'd36:   base = 16'hFEE5;
            6'd37:   base = 16'hFEE9;
            6'd38:   base = 16'hFEED;
            6'd39:   base = 16'hFEEF;
            6'd40:   base = 16'hFEF1;
            default: base = 16'h0000;
        endcase
        return base;
    endfunction

    // Letters that join on both sides and so have four forms
    function automatic logic four_forms(input logic [5:0] idx);
        logic ff;
        case (idx)
            6'd4, 6'd6, 6'd8, 6'd9, 6'd10, 6'd11, 6'd12,
            6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24,
            6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd40:
                ff = 1'b1;
            default:
                ff = 1'b0;
        endcase
        return ff;
    endfunction

    // Pick the contextual form of a code point from its neighbours
    function automatic logic [C_CP_W-1:0] shape(input logic [C_CP_W-1:0] cp,
                                                input logic prev_j,
                                                input logic next_j);
        logic [10:0]       diff;
        logic [5:0]        idx;
        logic [1:0]        off;
        logic [C_CP_W-1:0] res;
        diff = cp[10:0] - C_FIRST_LETTER[10:0];
        idx  = diff[5:0];
        if (prev_j && next_j) begin
            off = four_forms(idx) ? 2'd3 : 2'd1;
        end else if (prev_j) begin
            off = 2'd1;
        end else if (next_j) begin
            off = four_forms(idx) ? 2'd2 : 2'd0;
        end else begin
            off = 2'd0;
        end
        if (letter_joins(cp)) begin
            res = {5'd0, form_base(idx) + {14'd0, off}};
        end else begin
            res = cp;
        end
        return res;
    endfunction

    // UTF-8 length code of a code point
    function automatic t_len point_len(input logic [C_CP_W-1:0] cp);
        t_len len;
        if (cp < 21'h000080) begin
            len = LEN_1;
        end else if (cp < 21'h000800) begin
            len = LEN_2;
        end else if (cp < 21'h010000) begin
            len = LEN_3;
        end else begin
            len = LEN_4;
        end
        return len;
    endfunction

    // UTF-8 byte at position pos of a code point of the given length
    function automatic logic [7:0] utf8_byte(input logic [C_CP_W-1:0] cp,
                                             input t_len len,
                                             input logic [1:0] pos);
        logic [7:0] b;
        b = 8'h00;
        case (len)
            LEN_1: b = {1'b0, cp[6:0]};
            LEN_2: begin
                case (pos)
                    2'd0:    b = C_LEAD2 | {3'd0, cp[10:6]};
                    default: b = C_CONT | {2'd0, cp[5:0]};
                endcase
            end
            LEN_3: begin
                case (pos)
                    2'd0:    b = C_LEAD3 | {4'd0, cp[15:12]};
                    2'd1:    b = C_CONT | {2'd0, cp[11:6]};
                    default: b = C_CONT | {2'd0, cp[5:0]};
                endcase
            end
            LEN_4: begin
                case (pos)
                    2'd0:    b = C_LEAD4 | {5'd0, cp[20:18]};
                    2'd1:    b = C_CONT | {2'd0, cp[17:12]};
                    2'd2:    b = C_CONT | {2'd0, cp[11:6]};
                    default: b = C_CONT | {2'd0, cp[5:0]};
                endcase
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

>>> design/acs_front.sv
// Front end of the shaper: accepts raw bytes, decodes UTF-8 and shapes code points.
// Pushes one job per input byte that yields output into the job queue.
// Depends on acs_pkg.
`default_nettype none

module acs_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [7:0]    i_in_byte,
    input  wire logic          i_end_of_text,
    input  wire logic          i_q_full,
    output logic               o_push,
    output acs_pkg::t_job      o_job
);
    import acs_pkg::*;

    logic [C_CP_W-1:0] r_partial, n_partial;
    logic [1:0]        r_remain, n_remain;
    logic [C_CP_W-1:0] r_held, n_held;
    logic              r_held_valid, n_held_valid;
    logic              r_before, n_before;

    logic              accept;
    logic              have_new;
    logic [C_CP_W-1:0] new_cp;
    logic              first_out;
    logic              flush_out;
    logic [C_CP_W-1:0] first_cp;
    logic [C_CP_W-1:0] flush_cp;
    logic              flush_before;
    logic [C_CP_W-1:0] flush_shaped;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;

    // Decode the byte against the sequence in progress
    always_comb begin
        n_partial = r_partial;
        n_remain  = r_remain;
        have_new  = 1'b0;
        new_cp    = '0;
        if (r_remain != 2'd0) begin
            n_partial = {r_partial[14:0], i_in_byte[5:0]};
            n_remain  = r_remain - 2'd1;
            if (r_remain == 2'd1) begin
                have_new = 1'b1;
                new_cp   = {r_partial[14:0], i_in_byte[5:0]};
            end
        end else if (i_in_byte < C_ASCII_TOP) begin
            have_new = 1'b1;
            new_cp   = {13'd0, i_in_byte};
        end else if (i_in_byte[7:5] == 3'b110) begin
            n_partial = {16'd0, i_in_byte[4:0]};
            n_remain  = 2'd1;
        end else if (i_in_byte[7:4] == 4'b1110) begin
            n_partial = {17'd0, i_in_byte[3:0]};
            n_remain  = 2'd2;
        end else if (i_in_byte[7:3] == 5'b11110) begin
            n_partial = {18'd0, i_in_byte[2:0]};
            n_remain  = 2'd3;
        end
    end

    // Shape the held point and the point flushed at end of text
    always_comb begin
        first_out    = have_new && r_held_valid;
        first_cp     = shape(r_held, r_before, letter_joins(new_cp));
        flush_out    = i_end_of_text && (have_new || r_held_valid);
        flush_cp     = have_new ? new_cp : r_held;
        flush_before = have_new ? (r_held_valid && letter_joins(r_held)) : r_before;
        flush_shaped = shape(flush_cp, flush_before, 1'b0);

        o_job.flush = i_end_of_text;
        if (first_out) begin
            o_job.cp_a  = first_cp;
            o_job.cp_b  = flush_shaped;
            o_job.has_b = flush_out;
        end else begin
            o_job.cp_a  = flush_shaped;
            o_job.cp_b  = flush_shaped;
            o_job.has_b = 1'b0;
        end
        o_push = accept && (first_out || flush_out);
    end

    // Advance the held point; end of text returns everything to reset
    always_comb begin
        n_held       = r_held;
        n_held_valid = r_held_valid;
        n_before     = r_before;
        if (have_new) begin
            n_held       = new_cp;
            n_held_valid = 1'b1;
            n_before     = r_held_valid && letter_joins(r_held);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial    <= '0;
            r_remain     <= '0;
            r_held       <= '0;
            r_held_valid <= 1'b0;
            r_before     <= 1'b0;
        end else if (accept) begin
            if (i_end_of_text) begin
                r_partial    <= '0;
                r_remain     <= '0;
                r_held       <= '0;
                r_held_valid <= 1'b0;
                r_before     <= 1'b0;
            end else begin
                r_partial    <= n_partial;
                r_remain     <= n_remain;
                r_held       <= n_held;
                r_held_valid <= n_held_valid;
                r_before     <= n_before;
            end
        end
    end

endmodule

`default_nettype wire

>>> design/acs_queue.sv
// Short job queue between the front end and the byte serialiser.
// Register-based FIFO with a head entry visible for pop.
// Depends on acs_pkg.
`default_nettype none

module acs_queue #(
    parameter int unsigned DEPTH = acs_pkg::C_QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  acs_pkg::t_job      i_job,
    input  wire logic          i_pop,
    output acs_pkg::t_job      o_head,
    output logic               o_nonempty,
    output logic               o_full
);
    import acs_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_job          r_slot [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_head     = r_slot[r_rd_ptr];
    assign o_nonempty = (r_count != '0);
    assign o_full     = (r_count == CW'(DEPTH));

    // Hold the entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    // Advance the pointers and the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> design/acs_back.sv
// Back end of the shaper: turns queued code points into UTF-8 bytes, one per cycle while the receiver does not stall.
// Drives the registered output channel and marks run and text ends.
// Depends on acs_pkg.
`default_nettype none

module acs_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  acs_pkg::t_job      i_head,
    input  wire logic          i_nonempty,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [7:0]         o_out_byte,
    output logic               o_last_in_run,
    output logic               o_text_done
);
    import acs_pkg::*;

    logic              r_busy;
    logic [C_CP_W-1:0] r_cp;
    logic [C_CP_W-1:0] r_cp2;
    logic              r_has2;
    logic              r_flush;
    logic [1:0]        r_pos;

    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_last;
    logic              r_out_done;

    t_len              len;
    logic              adv;
    logic              emit;
    logic              pt_last;
    logic              job_last;

    assign o_valid       = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_in_run = r_out_last;
    assign o_text_done   = r_out_done;

    // Work out the current byte and whether it closes the job
    always_comb begin
        len      = point_len(r_cp);
        adv      = !r_out_valid || !i_stall;
        emit     = r_busy && adv;
        pt_last  = (r_pos == 2'(len));
        job_last = pt_last && !r_has2;
        o_pop    = i_nonempty && (!r_busy || (emit && job_last));
    end

    // Output register: load a byte, or drop the valid once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (adv) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= utf8_byte(r_cp, len, r_pos);
            r_out_last <= job_last;
            r_out_done <= job_last && r_flush;
        end
    end

    // Step through the bytes of the current job, loading the next from the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
        end else if (emit && job_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cp    <= i_head.cp_a;
            r_cp2   <= i_head.cp_b;
            r_has2  <= i_head.has_b;
            r_flush <= i_head.flush;
            r_pos   <= 2'd0;
        end else if (emit) begin
            if (pt_last) begin
                r_cp   <= r_cp2;
                r_has2 <= 1'b0;
                r_pos  <= 2'd0;
            end else begin
                r_pos <= r_pos + 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

>>> design/arabic_contextual_shaper_unit.sv
// Top level of the Arabic contextual shaper on a UTF-8 byte stream.
// Connects the decoding front end, the job queue and the byte serialiser; uses acs_pkg.
//
// Takes one UTF-8 byte per cycle while the job queue has room and emits the shaped
// text as UTF-8, one byte per cycle while the receiver does not stall. Each code point
// is held back one place so that both neighbours are known; a joining Arabic letter
// leaves as its isolated, initial, final or medial presentation form. The front end
// decodes and shapes a byte in the cycle it is transferred and queues the resulting
// code points (up to two per byte); the back end serialises them. An input byte
// yields 0 to 8 output bytes, and a shaped letter leaves as three bytes. Input is
// stalled only while the job queue is full. The first output byte of an input transfer
// passes through the job queue, the back end's job register and the output register.
`default_nettype none

module arabic_contextual_shaper_unit #(
    parameter int unsigned QUEUE_DEPTH = acs_pkg::C_QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_end_of_text,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_last_in_run,
    output logic            o_text_done
);
    import acs_pkg::*;

    logic push;
    logic pop;
    logic q_full;
    logic q_nonempty;
    t_job push_job;
    t_job head_job;

    // Decode and shape
    acs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_job         (push_job)
    );

    // Decouple the two ends
    acs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_job      (push_job),
        .i_pop      (pop),
        .o_head     (head_job),
        .o_nonempty (q_nonempty),
        .o_full     (q_full)
    );

    // Serialise to bytes
    acs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head_job),
        .i_nonempty    (q_nonempty),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_last_in_run (o_last_in_run),
        .o_text_done   (o_text_done)
    );

endmodule

`default_nettype wire

>>> tb/sv/acs_shaping_checker.sv
// Channel monitor and shaping predictor for arabic_contextual_shaper_unit.
// Predicts the shaped UTF-8 bytes of every input transfer and compares each output transfer.
// Depends on acs_pkg for the joining letter ranges and the UTF-8 framing constants.
`default_nettype none

module acs_shaping_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_stall,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_end_of_text,
    input  wire logic       i_out_valid,
    input  wire logic       i_out_stall,
    input  wire logic [7:0] i_out_byte,
    input  wire logic       i_last_in_run,
    input  wire logic       i_text_done,
    output int              o_error_count,
    output int              o_pending
);

    // Letters with four forms, one bit per letter counted from U+0622
    localparam logic [40:0] DUAL_JOIN_MASK = 41'h13F_81FE_1F50;
    localparam logic [20:0] FIRST_FORM     = 21'h00FE81;
    localparam int unsigned GAP_SLOT_FIRST = 25;
    localparam int unsigned GAP_SLOT_LAST  = 30;

    typedef struct packed {
        logic [7:0] value;
        logic       run_end;
        logic       text_end;
    } t_shaped_byte;

    t_shaped_byte expected_bytes[$];
    t_shaped_byte oldest;

    // Decoder and hold-back state of the prediction
    logic [20:0] accum_point;
    logic [1:0]  cont_left;
    logic [20:0] held_point;
    logic        held_ok;
    logic        held_prev_joins;

    // Bytes caused by the transfer being predicted
    logic [7:0]  run_bytes [0:7];
    int          run_len;

    int          error_count;
    int          pending;

    assign o_error_count = error_count;
    assign o_pending     = pending;

    function automatic logic is_joining(input logic [20:0] cp);
        return ((cp >= acs_pkg::C_FIRST_LETTER) && (cp <= acs_pkg::C_GAP_LOW)) ||
               ((cp >= acs_pkg::C_GAP_HIGH) && (cp <= acs_pkg::C_LAST_LETTER));
    endfunction

    // Presentation form from the neighbours; isolated forms step by 2 or 4 per letter
    function automatic logic [20:0] contextual_form(input logic [20:0] cp,
                                                    input logic prev_j,
                                                    input logic next_j);
        int unsigned slot;
        int unsigned j;
        logic [20:0] form;
        logic        dual;
        if (!is_joining(cp)) begin
            return cp;
        end
        slot = 32'(cp - acs_pkg::C_FIRST_LETTER);
        form = FIRST_FORM;
        for (j = 0; j < slot; j++) begin
            if (j < GAP_SLOT_FIRST || j > GAP_SLOT_LAST) begin
                form = form + (DUAL_JOIN_MASK[j] ? 21'd4 : 21'd2);
            end
        end
        dual = DUAL_JOIN_MASK[slot];
        if (prev_j && next_j) begin
            form = form + (dual ? 21'd3 : 21'd1);
        end else if (prev_j) begin
            form = form + 21'd1;
        end else if (next_j) begin
            form = form + (dual ? 21'd2 : 21'd0);
        end
        return form;
    endfunction

    function automatic void append_byte(input logic [7:0] b);
        if (run_len < 8) begin
            run_bytes[run_len] = b;
            run_len++;
        end
    endfunction

    // Encode one code point as UTF-8
    function automatic void append_point(input logic [20:0] cp);
        if (cp < 21'h000080) begin
            append_byte({1'b0, cp[6:0]});
        end else if (cp < 21'h000800) begin
            append_byte(acs_pkg::C_LEAD2 | {3'd0, cp[10:6]});
            append_byte(acs_pkg::C_CONT | {2'd0, cp[5:0]});
        end else if (cp < 21'h010000) begin
            append_byte(acs_pkg::C_LEAD3 | {4'd0, cp[15:12]});
            append_byte(acs_pkg::C_CONT | {2'd0, cp[11:6]});
            append_byte(acs_pkg::C_CONT | {2'd0, cp[5:0]});
        end else begin
            append_byte(acs_pkg::C_LEAD4 | {5'd0, cp[20:18]});
            append_byte(acs_pkg::C_CONT | {2'd0, cp[17:12]});
            append_byte(acs_pkg::C_CONT | {2'd0, cp[11:6]});
            append_byte(acs_pkg::C_CONT | {2'd0, cp[5:0]});
        end
    endfunction

    function automatic void clear_text_state();
        accum_point     = '0;
        cont_left       = '0;
        held_point      = '0;
        held_ok         = 1'b0;
        held_prev_joins = 1'b0;
    endfunction

    // Advance the prediction by one input transfer and queue the bytes it causes
    task automatic predict_transfer(input logic [7:0] b, input logic eot);
        logic         got_point;
        logic [20:0]  new_point;
        logic         new_joins;
        logic         held_joins;
        t_shaped_byte item;
        int           k;
        got_point  = 1'b0;
        new_point  = '0;
        held_joins = 1'b0;
        run_len    = 0;

        // assemble the code point; bad leads fall through untouched
        if (cont_left != 2'd0) begin
            accum_point = {accum_point[14:0], b[5:0]};
            cont_left   = cont_left - 2'd1;
            if (cont_left == 2'd0) begin
                got_point = 1'b1;
                new_point = accum_point;
            end
        end else if (b < acs_pkg::C_ASCII_TOP) begin
            got_point = 1'b1;
            new_point = {13'd0, b};
        end else if ((b & 8'hE0) == acs_pkg::C_LEAD2) begin
            accum_point = {16'd0, b[4:0]};
            cont_left   = 2'd1;
        end else if ((b & 8'hF0) == acs_pkg::C_LEAD3) begin
            accum_point = {17'd0, b[3:0]};
            cont_left   = 2'd2;
        end else if ((b & 8'hF8) == acs_pkg::C_LEAD4) begin
            accum_point = {18'd0, b[2:0]};
            cont_left   = 2'd3;
        end

        // release the held point now that its follower is known
        if (got_point) begin
            new_joins = is_joining(new_point);
            if (held_ok) begin
                append_point(contextual_form(held_point, held_prev_joins, new_joins));
                held_joins = is_joining(held_point);
            end
            held_point      = new_point;
            held_ok         = 1'b1;
            held_prev_joins = held_joins;
        end

        // flush at the end of the text and start afresh
        if (eot) begin
            if (held_ok) begin
                append_point(contextual_form(held_point, held_prev_joins, 1'b0));
            end
            clear_text_state();
        end

        for (k = 0; k < run_len; k++) begin
            item.value    = run_bytes[k];
            item.run_end  = (k == run_len - 1);
            item.text_end = eot && (k == run_len - 1);
            expected_bytes.insert(expected_bytes.size(), item);
        end
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            error_count++;
        end
    endtask

    initial begin
        error_count = 0;
        pending     = 0;
        run_len     = 0;
        clear_text_state();
    end

    // Compare output transfers first, then predict the input transfer of the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_text_state();
            expected_bytes.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_bytes.size() == 0) begin
                    $error("out_byte: expected nothing, got %h", i_out_byte);
                    error_count++;
                end else begin
                    oldest = expected_bytes.pop_front();
                    compare_field("out_byte", oldest.value, i_out_byte);
                    compare_field("last_in_run", {7'd0, oldest.run_end},
                                  {7'd0, i_last_in_run});
                    compare_field("text_done", {7'd0, oldest.text_end},
                                  {7'd0, i_text_done});
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_transfer(i_in_byte, i_end_of_text);
            end
        end
        pending = expected_bytes.size();
    end

endmodule

`default_nettype wire

>>> tb/sv/tb_arabic_contextual_shaper_unit.sv
// Testbench top for arabic_contextual_shaper_unit: UTF-8 text stimulus, receiver stalls, verdict.
// Prediction and comparison live in acs_shaping_checker; depends on acs_pkg and the design.
`default_nettype none

module tb_arabic_contextual_shaper_unit;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned HOLD_CYCLES  = 80;
    localparam int unsigned TAIL_CYCLES  = 16;
    localparam int unsigned RANDOM_BYTES = 450;
    localparam int unsigned IDLE_PERCENT = 37;

    localparam logic [20:0] CP_HAMZA   = 21'h000621;
    localparam logic [20:0] CP_BEH     = 21'h000628;
    localparam logic [20:0] CP_TATWEEL = 21'h000640;
    localparam logic [20:0] CP_YEH     = 21'h00064A;
    localparam logic [20:0] CP_FACE    = 21'h01F600;
    localparam logic [20:0] CP_TOP     = 21'h1FFFFF;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_in_byte;
    logic        i_end_of_text;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_out_byte;
    logic        o_last_in_run;
    logic        o_text_done;

    int          error_count;
    int          pending;
    bit          sender_gaps;
    bit          rx_calm;
    int unsigned hold_cycles_left;
    int unsigned bytes_offered;
    int unsigned cycle_count;
    int unsigned phase_base;

    arabic_contextual_shaper_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_last_in_run (o_last_in_run),
        .o_text_done   (o_text_done)
    );

    acs_shaping_checker shape_watch (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_out_byte    (o_out_byte),
        .i_last_in_run (o_last_in_run),
        .i_text_done   (o_text_done),
        .o_error_count (error_count),
        .o_pending     (pending)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Receiver stall: long hold when asked, otherwise random or open
    initial begin
        i_stall          = 1'b0;
        rx_calm          = 1'b0;
        hold_cycles_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles_left != 0) begin
                i_stall <= 1'b1;
                hold_cycles_left = hold_cycles_left - 1;
            end else if (rx_calm) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(0, 99) < IDLE_PERCENT);
            end
        end
    end

    // Abort a hung run
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_arabic_contextual_shaper_unit: done, errors");
        $finish;
    end

    // Offer one byte from a falling edge and hold it until the transfer
    task automatic offer_byte(input logic [7:0] b, input logic eot);
        bit taken;
        while (sender_gaps && ($urandom_range(0, 99) < IDLE_PERCENT)) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_in_byte     <= b;
        i_end_of_text <= eot;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !o_stall;
            @(negedge i_clk);
        end
        bytes_offered++;
    endtask

    // Send a code point as UTF-8, end-of-text on its last byte if asked
    task automatic send_point(input logic [20:0] cp, input logic eot);
        if (cp < 21'h000080) begin
            offer_byte({1'b0, cp[6:0]}, eot);
        end else if (cp < 21'h000800) begin
            offer_byte(acs_pkg::C_LEAD2 | {3'd0, cp[10:6]}, 1'b0);
            offer_byte(acs_pkg::C_CONT | {2'd0, cp[5:0]}, eot);
        end else if (cp < 21'h010000) begin
            offer_byte(acs_pkg::C_LEAD3 | {4'd0, cp[15:12]}, 1'b0);
            offer_byte(acs_pkg::C_CONT | {2'd0, cp[11:6]}, 1'b0);
            offer_byte(acs_pkg::C_CONT | {2'd0, cp[5:0]}, eot);
        end else begin
            offer_byte(acs_pkg::C_LEAD4 | {5'd0, cp[20:18]}, 1'b0);
            offer_byte(acs_pkg::C_CONT | {2'd0, cp[17:12]}, 1'b0);
            offer_byte(acs_pkg::C_CONT | {2'd0, cp[11:6]}, 1'b0);
            offer_byte(acs_pkg::C_CONT | {2'd0, cp[5:0]}, eot);
        end
    endtask

    // Mostly Arabic letters, with ASCII and longer encodings mixed in
    function automatic logic [20:0] pick_point();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 72) begin
            return 21'(CP_HAMZA + $urandom_range(0, 41));
        end else if (roll < 84) begin
            return 21'($urandom_range(0, 127));
        end else if (roll < 91) begin
            return 21'($urandom_range(128, 2047));
        end else if (roll < 96) begin
            return 21'($urandom_range(2048, 65535));
        end
        return 21'($urandom_range(65536, 21'h1FFFFF));
    endfunction

    // Lead byte plus too few continuation bytes, the last one ending the text
    task automatic send_cut_off();
        int unsigned total;
        int unsigned conts;
        int unsigned k;
        logic [7:0]  lead;
        total = $urandom_range(2, 4);
        conts = $urandom_range(0, total - 2);
        if (total == 2) begin
            lead = acs_pkg::C_LEAD2 | 8'($urandom_range(0, 31));
        end else if (total == 3) begin
            lead = acs_pkg::C_LEAD3 | 8'($urandom_range(0, 15));
        end else begin
            lead = acs_pkg::C_LEAD4 | 8'($urandom_range(0, 7));
        end
        offer_byte(lead, conts == 0);
        for (k = 0; k < conts; k++) begin
            offer_byte(acs_pkg::C_CONT | 8'($urandom_range(0, 63)), k == conts - 1);
        end
    endtask

    // One text: well-formed points, stray bytes now and then, and a varied ending
    task automatic send_text();
        int unsigned len;
        int unsigned k;
        int unsigned ending;
        len    = $urandom_range(1, 10);
        ending = $urandom_range(0, 99);
        for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 99) < 4) begin
                offer_byte(8'($urandom_range(0, 255)), 1'b0);
            end
            send_point(pick_point(), (k == len - 1) && (ending < 80));
        end
        if (ending >= 90) begin
            offer_byte(8'($urandom_range(0, 255)), 1'b1);
        end else if (ending >= 80) begin
            send_cut_off();
        end
    endtask

    task automatic send_texts_until(input int unsigned target);
        while (bytes_offered < target) begin
            send_text();
        end
    endtask

    // Drop valid and wait for every expected byte
    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Change the receiver behaviour at a rising edge, clear of its falling-edge update
    task automatic set_receiver(input bit calm, input int unsigned hold);
        i_valid <= 1'b0;
        @(posedge i_clk);
        rx_calm          = calm;
        hold_cycles_left = hold;
        @(negedge i_clk);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_in_byte     = 8'h00;
        i_end_of_text = 1'b0;
        sender_gaps   = 1'b1;
        bytes_offered = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: byte extremes, contextual forms, named corner cases
        offer_byte(8'h00, 1'b0);
        offer_byte(8'hFF, 1'b0);                    // bad lead, skipped
        send_point(CP_BEH, 1'b0);                   // initial
        send_point(CP_BEH, 1'b0);                   // medial
        send_point(CP_BEH, 1'b1);                   // final, then flush
        offer_byte(acs_pkg::C_CONT, 1'b1);          // empty flush, nothing held
        send_point(CP_HAMZA, 1'b0);                 // hamza does not join
        send_point(CP_TATWEEL, 1'b0);               // gap does not join
        send_point(CP_YEH, 1'b0);
        offer_byte(8'hE2, 1'b0);                    // cut-off sequence at end of text
        offer_byte(8'h82, 1'b1);
        offer_byte(8'hC3, 1'b0);                    // continuation top bits ignored
        offer_byte(8'hFF, 1'b0);
        send_point(CP_FACE, 1'b0);
        send_point(CP_TOP, 1'b1);                   // two four-byte points at once
        wait_for_results();

        // random texts with idling on both sides
        phase_base = bytes_offered;
        send_texts_until(phase_base + 200);
        wait_for_results();

        // long stretch without idling
        sender_gaps = 1'b0;
        set_receiver(1'b1, 0);
        send_texts_until(phase_base + 330);

        // receiver holds off while the sender keeps offering
        set_receiver(1'b0, HOLD_CYCLES);
        send_texts_until(phase_base + 380);

        // back to random idling
        sender_gaps = 1'b1;
        send_texts_until(phase_base + RANDOM_BYTES);

        wait_for_results();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (error_count == 0 && pending == 0) begin
            $display("tb_arabic_contextual_shaper_unit: done, clean");
        end else begin
            $display("tb_arabic_contextual_shaper_unit: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
